// ===== rtl/fit_policy_block_allocator_core_assert.svh =====
// Assertion macros for the allocator RTL.
// No dependencies; included inside module bodies by bare file name.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset (reset is active low)
`define FPBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included
`define FPBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// No dependencies; imported by every RTL module of the block except fpba_ram.
`timescale 1ns / 1ps

package fpba_pkg;

    // Default sizing of the free-size table
    localparam int NUM_BLOCKS_DEF = 8;
    localparam int SIZE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int OP_W     = 1;
    localparam int SLOT_W   = 3;
    localparam int AMT_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CHOSEN_W = 3;
    localparam int LEFT_W   = 16;
    localparam int POLICY_W = 2;

    // Item operation codes
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_REQ  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOALLOC = 2'd2;

    // Placement policy codes (the unused code behaves as first fit)
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch a new item, clear the scan
        logic issue;     // read the next table entry
        logic finish;    // write back and load the result register
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last; // the read being issued is the last entry
        logic out_free;  // result register can take a new result
    } t_ctrl_stat;

endpackage

// ===== rtl/fpba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fpba_ctrl.sv =====
// Sequencing state machine of the allocator: accept, scan, drain, finish.
// Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [fpba_pkg::OP_W-1:0] i_op,
    output logic                  o_in_ready,
    input  fpba_pkg::t_ctrl_stat  i_stat,
    output fpba_pkg::t_ctrl_cmd   o_cmd
);

    import fpba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_ready;

    assign in_ready = (r_state == S_IDLE);

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = i_in_valid && in_ready;
        o_cmd.issue   = (r_state == S_SCAN);
        o_cmd.finish  = (r_state == S_DONE) && i_stat.out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_op == OP_REQ) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = in_ready;

endmodule

// ===== rtl/fpba_datapath.sv =====
// Datapath of the allocator: item registers, free-size table, scan and pick
// logic, write-back and result register. Depends on fpba_pkg, fpba_ram and the assert header.
`timescale 1ns / 1ps

module fpba_datapath #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpba_pkg::t_ctrl_cmd           i_cmd,
    output fpba_pkg::t_ctrl_stat          o_stat,
    input  logic                          i_cfg_we,
    input  logic [fpba_pkg::POLICY_W-1:0] i_cfg_wdata,
    input  logic [fpba_pkg::OP_W-1:0]     i_op,
    input  logic [fpba_pkg::SLOT_W-1:0]   i_block_slot,
    input  logic [fpba_pkg::AMT_W-1:0]    i_amount,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fpba_pkg::STATUS_W-1:0] o_status,
    output logic [fpba_pkg::CHOSEN_W-1:0] o_chosen_block,
    output logic [fpba_pkg::LEFT_W-1:0]   o_left_over
);

    import fpba_pkg::*;

    `include "fit_policy_block_allocator_core_assert.svh"

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CMP_W = SIZE_WIDTH + AMT_W;
    localparam int SX_W  = IDX_W + SLOT_W;
    localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = '1;
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [SX_W-1:0]       NB_SX    = SX_W'(NUM_BLOCKS);
    localparam logic [IDX_W:0]        NB_CHK   = (IDX_W + 1)'(NUM_BLOCKS);

    // Item and configuration registers
    logic [OP_W-1:0]       r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic [AMT_W-1:0]      r_amount;
    logic [POLICY_W-1:0]   r_fit_policy;

    // Table state
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [SIZE_WIDTH-1:0] rd_data;

    // Scan state
    logic [IDX_W-1:0]      r_idx;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_pend_idx;
    logic                  r_rd_vld;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [SIZE_WIDTH-1:0] r_best_size;

    // Result register
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [CHOSEN_W-1:0]   r_chosen;
    logic [LEFT_W-1:0]     r_left;

    logic [CMP_W-1:0]      amt_ext;
    logic [SIZE_WIDTH-1:0] load_size;
    logic [CMP_W-1:0]      load_left;
    logic [SX_W-1:0]       slot_sx;
    logic                  slot_ok;
    logic [IDX_W-1:0]      slot_addr;
    logic [SIZE_WIDTH-1:0] cand_size;
    logic                  cand_fits;
    logic                  cand_better;
    logic                  take;
    logic [SIZE_WIDTH-1:0] req_size;
    logic [CMP_W-1:0]      req_left;
    logic [SX_W-1:0]       best_sx;
    logic                  is_load;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [SIZE_WIDTH-1:0] ram_wdata;

    // Load: saturate the size, check the slot against the table depth
    assign amt_ext   = CMP_W'(r_amount);
    assign load_size = (amt_ext > CMP_W'(SIZE_MAX)) ? SIZE_MAX : amt_ext[SIZE_WIDTH-1:0];
    assign load_left = CMP_W'(load_size);
    assign slot_sx   = SX_W'(r_slot);
    assign slot_ok   = (slot_sx < NB_SX);
    assign slot_addr = slot_sx[IDX_W-1:0];
    assign is_load   = (r_op == OP_LOAD);

    // Candidate compare; an entry never written reads as size zero
    assign cand_size = r_rd_vld ? rd_data : '0;
    assign cand_fits = (CMP_W'(cand_size) >= amt_ext);

    always_comb begin
        case (r_fit_policy)
            POL_BEST:  cand_better = (cand_size < r_best_size);
            POL_WORST: cand_better = (cand_size > r_best_size);
            default:   cand_better = 1'b0;
        endcase
    end

    assign take = r_pend && cand_fits && (!r_found || cand_better);

    // Write-back of the chosen block
    assign req_size = r_best_size - amt_ext[SIZE_WIDTH-1:0];
    assign req_left = CMP_W'(req_size);
    assign best_sx  = SX_W'(r_best_idx);

    assign ram_we    = i_cmd.finish && (is_load ? slot_ok : r_found);
    assign ram_waddr = is_load ? slot_addr : r_best_idx;
    assign ram_wdata = is_load ? load_size : req_size;

    fpba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_slot   <= i_block_slot;
            r_amount <= i_amount;
        end
    end

    // Policy register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy <= POL_FIRST;
        end else if (i_cfg_we) begin
            r_fit_policy <= i_cfg_wdata;
        end
    end

    // Valid bits of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[ram_waddr] <= 1'b1;
        end
    end

    // Scan control: one read per cycle, compare in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_pend <= i_cmd.issue;
            if (i_cmd.capture) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Scan payload
    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_idx;
        r_rd_vld   <= r_valid[r_idx];
        if (take) begin
            r_best_idx  <= r_pend_idx;
            r_best_size <= cand_size;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (is_load) begin
                r_status <= ST_LOADED;
                r_chosen <= r_slot;
                r_left   <= slot_ok ? load_left[LEFT_W-1:0] : '0;
            end else if (r_found) begin
                r_status <= ST_ALLOC;
                r_chosen <= best_sx[CHOSEN_W-1:0];
                r_left   <= req_left[LEFT_W-1:0];
            end else begin
                r_status <= ST_NOALLOC;
                r_chosen <= '0;
                r_left   <= '0;
            end
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.scan_last = (r_idx == LAST_IDX);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_chosen_block = r_chosen;
    assign o_left_over    = r_left;

    // Checks
    `FPBA_ASSERT(a_no_wb_mid_scan, i_clk, i_rst_n, i_cmd.finish |-> !r_pend, "write-back during scan")
    `FPBA_ASSERT(a_result_from_finish, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(i_cmd.finish), "result without finish")
    `FPBA_ASSERT(a_pick_in_range, i_clk, i_rst_n, r_found |-> ((IDX_W + 1)'(r_best_idx) < NB_CHK), "picked block out of range")

endmodule

// ===== rtl/fit_policy_block_allocator_core.sv =====
// Top level of the fit-policy block allocator: controller plus datapath.
// Depends on fpba_pkg, fpba_ctrl, fpba_datapath (and fpba_ram below it).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: i_op selects a
//   load (writes i_amount into block i_block_slot) or a request for i_amount.
//   Output channel (o_out_valid / i_out_ready) returns one result per item:
//   o_status, o_chosen_block, o_left_over.
//   i_cfg_we / i_cfg_wdata writes the placement policy (first, best, worst fit).
// Sequence:
//   A load skips the scan and goes straight to write-back and the result
//   register; the next item is taken once the block is back in idle.
//   A request reads the free-size table through its single read port, one
//   entry per cycle for all NUM_BLOCKS entries, then a compare step, a
//   write-back step and a return to idle before the next acceptance.
// Reset (synchronous, active low) empties the table and selects first fit.
// A result waits in the output register while the receiver stalls; the block
// still takes and works the next item, then holds it until that register frees.
`timescale 1ns / 1ps

module fit_policy_block_allocator_core #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fpba_pkg::POLICY_W-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [fpba_pkg::OP_W-1:0]     i_op,
    input  logic [fpba_pkg::SLOT_W-1:0]   i_block_slot,
    input  logic [fpba_pkg::AMT_W-1:0]    i_amount,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fpba_pkg::STATUS_W-1:0] o_status,
    output logic [fpba_pkg::CHOSEN_W-1:0] o_chosen_block,
    output logic [fpba_pkg::LEFT_W-1:0]   o_left_over
);

    import fpba_pkg::*;

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    // Sequencer
    fpba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Table, scan and result datapath
    fpba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (i_op),
        .i_block_slot   (i_block_slot),
        .i_amount       (i_amount),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_chosen_block (o_chosen_block),
        .o_left_over    (o_left_over)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for fit_policy_block_allocator_core: directed table, then random items.
// Depends on fpba_pkg and the allocator RTL; predicts untyped results with its own free-size table.
`timescale 1ns / 1ps

module testbench;
    import fpba_pkg::*;

    // Unused policy code, expected to behave as first fit
    localparam logic [POLICY_W-1:0] POL_ALIAS_FIRST = 2'd3;
    localparam int BLOCKS = NUM_BLOCKS_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHOSEN_W-1:0] blk;
        logic [LEFT_W-1:0]   left;
    } t_result;

    // One directed step: either a policy write or an item
    typedef struct {
        bit                  set_policy;
        logic [POLICY_W-1:0] policy;
        logic [OP_W-1:0]     op;
        logic [SLOT_W-1:0]   slot;
        logic [AMT_W-1:0]    amount;
        bit                  typed;
        t_result             want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [POLICY_W-1:0]   i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_op = OP_LOAD;
    logic [SLOT_W-1:0]     i_block_slot = '0;
    logic [AMT_W-1:0]      i_amount = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [CHOSEN_W-1:0]   o_chosen_block;
    logic [LEFT_W-1:0]     o_left_over;

    // Predictor state
    logic [AMT_W-1:0]      free_blocks [BLOCKS];
    logic [POLICY_W-1:0]   fit_sel;
    t_result               pending_results [$];
    t_dir_row              dir_rows [$];
    int                    fail_count = 0;
    bit                    idle_en = 1'b1;
    int                    out_stall_left = 0;

    fit_policy_block_allocator_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_block_slot   (i_block_slot),
        .i_amount       (i_amount),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_chosen_block (o_chosen_block),
        .o_left_over    (o_left_over)
    );

    always #1 i_clk = ~i_clk;

    // Apply one item to the free-size table and return the result it gives
    function automatic t_result alloc_predict(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                              logic [AMT_W-1:0] amt);
        t_result             r;
        bit                  found;
        int                  pick;
        logic [POLICY_W-1:0] pol;
        found = 1'b0;
        pick  = 0;
        pol   = (fit_sel == POL_BEST || fit_sel == POL_WORST) ? fit_sel : POL_FIRST;
        if (op == OP_LOAD) begin
            free_blocks[slot] = amt;
            r.status = ST_LOADED;
            r.blk    = slot;
            r.left   = amt;
            return r;
        end
        // Scan in index order; strict compare keeps ties on the lowest index
        for (int j = 0; j < BLOCKS; j++) begin
            if (free_blocks[j] >= amt) begin
                if (!found
                    || (pol == POL_BEST  && free_blocks[j] < free_blocks[pick])
                    || (pol == POL_WORST && free_blocks[j] > free_blocks[pick])) begin
                    pick  = j;
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            r.status = ST_NOALLOC;
            r.blk    = '0;
            r.left   = '0;
        end else begin
            free_blocks[pick] = free_blocks[pick] - amt;
            r.status = ST_ALLOC;
            r.blk    = pick[CHOSEN_W-1:0];
            r.left   = free_blocks[pick];
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void add_policy_row(logic [POLICY_W-1:0] pol);
        t_dir_row row;
        row = '{default: '0};
        row.set_policy = 1'b1;
        row.policy     = pol;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_item_row(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                         logic [AMT_W-1:0] amt, bit typed,
                                         logic [STATUS_W-1:0] st, logic [CHOSEN_W-1:0] blk,
                                         logic [LEFT_W-1:0] left);
        t_dir_row row;
        row = '{default: '0};
        row.op          = op;
        row.slot        = slot;
        row.amount      = amt;
        row.typed       = typed;
        row.want.status = st;
        row.want.blk    = blk;
        row.want.left   = left;
        dir_rows.push_back(row);
    endfunction

    // Offer one item, wait for acceptance, then record what it should give
    task automatic push_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                             logic [AMT_W-1:0] amt, bit typed, t_result want);
        t_result predicted;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_block_slot <= slot;
        i_amount     <= amt;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = alloc_predict(op, slot, amt);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Policy changes only once the block has drained
    task automatic write_policy(logic [POLICY_W-1:0] pol);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pol;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fit_sel = pol;
    endtask

    // Mostly requests sized from the current table so allocations keep happening
    task automatic random_item();
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [AMT_W-1:0]  amt;
        int                pick;
        pick = $urandom_range(0, BLOCKS - 1);
        slot = SLOT_W'($urandom_range(0, BLOCKS - 1));
        if ($urandom_range(0, 99) < 35) begin
            op = OP_LOAD;
            case ($urandom_range(0, 6))
                0: amt = AMT_W'($urandom_range(0, 65535));
                1: amt = 16'hFFFF;
                2: amt = '0;
                3: amt = free_blocks[pick];   // duplicate size, forces ties
                default: amt = AMT_W'($urandom_range(1, 400));
            endcase
        end else begin
            op = OP_REQ;
            case ($urandom_range(0, 7))
                0: amt = AMT_W'($urandom_range(0, 65535));
                1: amt = '0;
                2: amt = free_blocks[pick];   // exact fit
                3: amt = free_blocks[pick] + 1'b1;
                default: amt = AMT_W'($urandom_range(0, free_blocks[pick]));
            endcase
        end
        push_item(op, slot, amt, 1'b0, '0);
    endtask

    // Receiver stalls in bursts of random length
    always @(posedge i_clk) begin
        if (out_stall_left > 0) begin
            out_stall_left <= out_stall_left - 1;
            i_out_ready    <= 1'b0;
        end else if (idle_en && $urandom_range(0, 15) == 0) begin
            out_stall_left <= $urandom_range(0, 7);
            i_out_ready    <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected: status %0d block %0d left %0d",
                       o_status, o_chosen_block, o_left_over);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("chosen_block", want.blk, o_chosen_block);
                check_field("left_over", want.left, o_left_over);
            end
        end
    end

    initial begin : stimulus
        logic [POLICY_W-1:0] pol;
        fit_sel = POL_FIRST;
        for (int j = 0; j < BLOCKS; j++) free_blocks[j] = '0;

        // Empty table: zero request fits block 0, anything larger fails
        add_item_row(OP_REQ,  3'd0, 16'd0,     1'b1, ST_ALLOC,   3'd0, 16'd0);
        add_item_row(OP_REQ,  3'd7, 16'd1,     1'b1, ST_NOALLOC, 3'd0, 16'd0);
        add_item_row(OP_LOAD, 3'd0, 16'hFFFF,  1'b1, ST_LOADED,  3'd0, 16'hFFFF);
        add_item_row(OP_LOAD, 3'd7, 16'd0,     1'b1, ST_LOADED,  3'd7, 16'd0);
        add_item_row(OP_LOAD, 3'd3, 16'd100,   1'b1, ST_LOADED,  3'd3, 16'd100);
        add_item_row(OP_LOAD, 3'd5, 16'd300,   1'b1, ST_LOADED,  3'd5, 16'd300);
        add_item_row(OP_LOAD, 3'd1, 16'd50,    1'b1, ST_LOADED,  3'd1, 16'd50);
        // Largest request takes the full block, then nothing is left that big
        add_item_row(OP_REQ,  3'd0, 16'hFFFF,  1'b1, ST_ALLOC,   3'd0, 16'd0);
        add_item_row(OP_REQ,  3'd5, 16'hFFFF,  1'b1, ST_NOALLOC, 3'd0, 16'd0);
        add_item_row(OP_LOAD, 3'd0, 16'd200,   1'b1, ST_LOADED,  3'd0, 16'd200);
        add_item_row(OP_REQ,  3'd2, 16'd60,    1'b0, ST_LOADED,  3'd0, 16'd0);
        add_policy_row(POL_BEST);
        add_item_row(OP_REQ,  3'd6, 16'd60,    1'b0, ST_LOADED,  3'd0, 16'd0);
        add_policy_row(POL_WORST);
        add_item_row(OP_REQ,  3'd1, 16'd60,    1'b0, ST_LOADED,  3'd0, 16'd0);
        add_item_row(OP_REQ,  3'd4, 16'd0,     1'b0, ST_LOADED,  3'd0, 16'd0);
        add_policy_row(POL_ALIAS_FIRST);
        add_item_row(OP_REQ,  3'd0, 16'd10,    1'b0, ST_LOADED,  3'd0, 16'd0);
        add_policy_row(POL_BEST);
        // Zero request under best fit lands on the lowest empty block
        add_item_row(OP_REQ,  3'd0, 16'd0,     1'b0, ST_LOADED,  3'd0, 16'd0);
        add_item_row(OP_LOAD, 3'd2, 16'd40,    1'b1, ST_LOADED,  3'd2, 16'd40);
        add_item_row(OP_REQ,  3'd0, 16'd40,    1'b0, ST_LOADED,  3'd0, 16'd0);
        add_item_row(OP_REQ,  3'd0, 16'hFFFF,  1'b1, ST_NOALLOC, 3'd0, 16'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].set_policy)
                write_policy(dir_rows[k].policy);
            else
                push_item(dir_rows[k].op, dir_rows[k].slot, dir_rows[k].amount,
                          dir_rows[k].typed, dir_rows[k].want);
        end

        // Random phases, one policy each; the last runs without idling
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: pol = POL_FIRST;
                1: pol = POL_BEST;
                2: pol = POL_WORST;
                3: pol = POL_ALIAS_FIRST;
                default: pol = POLICY_W'($urandom_range(0, 3));
            endcase
            if (ph == 8) idle_en = 1'b0;
            write_policy(pol);
            repeat (128) random_item();
        end

        // Drain and let the tail settle
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("[fit_policy_block_allocator_core] OK");
        else
            $display("[fit_policy_block_allocator_core] ERROR");
        $finish;
    end

    // Run limit
    initial begin
        #500000;
        $display("[fit_policy_block_allocator_core] ERROR");
        $finish;
    end

endmodule
